// File: hdl/mas_pkg.sv
`timescale 1ns / 1ps
package mas_pkg;
   localparam int SIDE = 8;
   localparam int ADDR_W = 6;
   localparam int DATA_W = 32;

   localparam logic [2:0] MODE_LOAD_A = 3'd0;
   localparam logic [2:0] MODE_LOAD_B = 3'd1;
   localparam logic [2:0] MODE_ADD    = 3'd2;
   localparam logic [2:0] MODE_SUB    = 3'd3;
   localparam logic [2:0] MODE_MUL    = 3'd4;

   localparam logic [1:0] REG_A_ROWS = 2'd0;
   localparam logic [1:0] REG_A_COLS = 2'd1;
   localparam logic [1:0] REG_B_ROWS = 2'd2;
   localparam logic [1:0] REG_B_COLS = 2'd3;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_ERR = 2'd3;

   // One classified compute command handed from the front to the back.
   typedef struct packed {
      logic [1:0] op;
      logic [3:0] rows;
      logic [3:0] cols;
      logic [3:0] len;
   } cmd_type;

   localparam int CMD_W = $bits(cmd_type);

   function automatic logic [31:0] sat32(input logic signed [66:0] v);
      logic signed [66:0] mx;
      logic signed [66:0] mn;
      mx = 67'sd2147483647;
      mn = -67'sd2147483648;
      if (v > mx) return 32'h7FFF_FFFF;
      else if (v < mn) return 32'h8000_0000;
      else return v[31:0];
   endfunction
endpackage

// File: hdl/mas_ram.sv
`timescale 1ns / 1ps
module mas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hdl/mas_front.sv
`timescale 1ns / 1ps
module mas_front (
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [2:0]             mode,
   input  logic [3:0]             a_rows,
   input  logic [3:0]             a_cols,
   input  logic [3:0]             b_rows,
   input  logic [3:0]             b_cols,
   input  logic [4:0]             dim_limit,
   input  logic                   busy,
   output logic                   wr_a,
   output logic                   wr_b,
   output logic                   q_push,
   output mas_pkg::cmd_type       q_data,
   input  logic                   q_full
);
   import mas_pkg::*;

   logic dims_ok;
   logic ok;
   logic acc;

   // Loads wait until no compute command is queued or running, so that a
   // compute always sees the stores as they were when it was accepted.
   // Other words only need a free queue slot.
   assign in_ready = (mode == MODE_LOAD_A || mode == MODE_LOAD_B) ? !busy : !q_full;
   assign acc = in_valid && in_ready;
   assign wr_a = acc && (mode == MODE_LOAD_A);
   assign wr_b = acc && (mode == MODE_LOAD_B);

   assign dims_ok = (a_rows != 4'd0) && ({1'b0, a_rows} <= dim_limit) &&
                    (a_cols != 4'd0) && ({1'b0, a_cols} <= dim_limit) &&
                    (b_rows != 4'd0) && ({1'b0, b_rows} <= dim_limit) &&
                    (b_cols != 4'd0) && ({1'b0, b_cols} <= dim_limit);

   always_comb begin
      ok = 1'b0;
      q_data.rows = a_rows;
      q_data.cols = a_cols;
      q_data.len = a_cols;
      q_data.op = OP_ERR;
      case (mode)
         MODE_ADD: begin
            ok = dims_ok && a_rows == b_rows && a_cols == b_cols;
            q_data.op = ok ? OP_ADD : OP_ERR;
         end
         MODE_SUB: begin
            ok = dims_ok && a_rows == b_rows && a_cols == b_cols;
            q_data.op = ok ? OP_SUB : OP_ERR;
         end
         MODE_MUL: begin
            ok = dims_ok && a_cols == b_rows;
            q_data.cols = b_cols;
            q_data.op = ok ? OP_MUL : OP_ERR;
         end
         default: ok = 1'b0;
      endcase
   end

   assign q_push = acc && (mode == MODE_ADD || mode == MODE_SUB || mode == MODE_MUL);
endmodule

// File: hdl/mas_queue.sv
`timescale 1ns / 1ps
module mas_queue #(
   parameter int WIDTH = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head,
   input  logic             pop
);
   // Two-entry queue: slot 0 is the head.
   logic [WIDTH-1:0] data_ff [2];
   logic [WIDTH-1:0] data_in [2];
   logic [1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head = data_ff[0];

   always_comb begin
      data_in = data_ff;
      cnt_in = cnt_ff;
      if (pop && not_empty) begin
         data_in[0] = data_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push && !full) begin
         data_in[cnt_in[0]] = push_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_in;
      data_ff <= data_in;
   end
endmodule

// File: hdl/mas_back.sv
`timescale 1ns / 1ps
module mas_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  mas_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             busy,
   output logic [5:0]       rd_a_addr,
   output logic [5:0]       rd_b_addr,
   input  logic [31:0]      rd_a_data,
   input  logic [31:0]      rd_b_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [31:0]      out_value,
   output logic [2:0]       out_row,
   output logic [2:0]       out_col,
   output logic             out_last,
   output logic             out_err
);
   import mas_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_MULT = 3'd2;
   localparam logic [2:0] ST_ACC  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] st_ff, st_in;
   logic [2:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [1:0] op_ff, op_in;
   logic [3:0] rows_ff, rows_in, cols_ff, cols_in, len_ff, len_in;
   logic signed [66:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic last_k;
   logic last_elem;
   logic vld_ff, vld_in;
   logic [31:0] val_ff, val_in;
   logic [2:0] orow_ff, orow_in, ocol_ff, ocol_in;
   logic olast_ff, olast_in, oerr_ff, oerr_in;

   assign busy = (st_ff != ST_IDLE);
   assign last_k = ({1'b0, k_ff} + 4'd1 == len_ff) || op_ff != OP_MUL;
   assign last_elem = ({1'b0, r_ff} + 4'd1 == rows_ff) && ({1'b0, c_ff} + 4'd1 == cols_ff);
   assign rd_a_addr = (op_ff == OP_MUL) ? {r_ff, k_ff} : {r_ff, c_ff};
   assign rd_b_addr = (op_ff == OP_MUL) ? {k_ff, c_ff} : {r_ff, c_ff};

   assign out_valid = vld_ff;
   assign out_value = val_ff;
   assign out_row = orow_ff;
   assign out_col = ocol_ff;
   assign out_last = olast_ff;
   assign out_err = oerr_ff;

   always_comb begin
      st_in = st_ff;
      r_in = r_ff; c_in = c_ff; k_in = k_ff;
      op_in = op_ff; rows_in = rows_ff; cols_in = cols_ff; len_in = len_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      cmd_pop = 1'b0;
      vld_in = vld_ff && !out_ready;
      val_in = val_ff; orow_in = orow_ff; ocol_in = ocol_ff;
      olast_in = olast_ff; oerr_in = oerr_ff;
      case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               op_in = cmd.op; rows_in = cmd.rows; cols_in = cmd.cols; len_in = cmd.len;
               r_in = 3'd0; c_in = 3'd0; k_in = 3'd0; acc_in = '0;
               st_in = (cmd.op == OP_ERR) ? ST_OUT : ST_READ;
            end
         end
         ST_READ: st_in = ST_MULT;  // stores answer in the cycle after the address
         ST_MULT: begin
            case (op_ff)
               OP_ADD: prod_in = 64'(signed'(rd_a_data)) + 64'(signed'(rd_b_data));
               OP_SUB: prod_in = 64'(signed'(rd_a_data)) - 64'(signed'(rd_b_data));
               default: prod_in = signed'(rd_a_data) * signed'(rd_b_data);
            endcase
            st_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in = acc_ff + 67'(prod_ff);
            if (last_k) st_in = ST_OUT;
            else begin
               k_in = k_ff + 3'd1;
               st_in = ST_READ;
            end
         end
         ST_OUT: begin
            if (!vld_ff || out_ready) begin
               vld_in = 1'b1;
               if (op_ff == OP_ERR) begin
                  val_in = '0; orow_in = '0; ocol_in = '0; olast_in = 1'b1; oerr_in = 1'b1;
                  st_in = ST_IDLE;
               end else begin
                  val_in = sat32(acc_ff);
                  orow_in = r_ff; ocol_in = c_ff; olast_in = last_elem; oerr_in = 1'b0;
                  acc_in = '0; k_in = 3'd0;
                  if (last_elem) st_in = ST_IDLE;
                  else begin
                     st_in = ST_READ;
                     if ({1'b0, c_ff} + 4'd1 == cols_ff) begin
                        c_in = 3'd0;
                        r_in = r_ff + 3'd1;
                     end else c_in = c_ff + 3'd1;
                  end
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         vld_ff <= vld_in;
      end
      r_ff <= r_in; c_ff <= c_in; k_ff <= k_in;
      op_ff <= op_in; rows_ff <= rows_in; cols_ff <= cols_in; len_ff <= len_in;
      acc_ff <= acc_in; prod_ff <= prod_in;
      val_ff <= val_in; orow_ff <= orow_in; ocol_ff <= ocol_in;
      olast_ff <= olast_in; oerr_ff <= oerr_in;
   end
endmodule

// File: hdl/matrix_add_sub_multiply.sv
`timescale 1ns / 1ps
// Load words are held off while a compute is queued or running.
// Each result element is built term by term: the back end reads both stores,
// then adds, subtracts or multiplies, then accumulates, one term for add and
// subtract and len terms for a multiply, through the single read port of each
// store and the shared multiplier. Reset is synchronous: control state, shapes (all 1).
module matrix_add_sub_multiply #(
   parameter int MAX_DIM = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], row_index[5:3], col_index[8:6], element_value[40:9], zero fill
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value[31:0], out_row[34:32], out_col[37:35], zero fill
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   // dims_error
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);
   import mas_pkg::*;

   // The usable shape limit is the smaller of MAX_DIM and the store side.
   localparam int LIMIT = (MAX_DIM < SIDE) ? MAX_DIM : SIDE;

   logic [3:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;
   logic [2:0] mode;
   logic [5:0] wr_addr;
   logic [31:0] wr_value;
   logic wr_a, wr_b, q_push, q_full, q_ne, q_pop;
   logic back_busy;
   cmd_type q_in, q_head;
   logic [5:0] rd_a_addr, rd_b_addr;
   logic [31:0] rd_a_data, rd_b_data;
   logic [31:0] res_value;
   logic [2:0] res_row, res_col;

   assign mode = req_tdata[2:0];
   assign wr_addr = {req_tdata[5:3], req_tdata[8:6]};
   assign wr_value = req_tdata[40:9];

   // Shapes must only be written while the block is idle; the block itself does not enforce it.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff <= 4'd1; a_cols_ff <= 4'd1; b_rows_ff <= 4'd1; b_cols_ff <= 4'd1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_A_ROWS: a_rows_ff <= csr_data;
            REG_A_COLS: a_cols_ff <= csr_data;
            REG_B_ROWS: b_rows_ff <= csr_data;
            REG_B_COLS: b_cols_ff <= csr_data;
            default: a_rows_ff <= a_rows_ff;
         endcase
      end
   end

   // Front end: classifies words, writes loads, queues compute commands.
   mas_front u_front (
      .in_valid(req_tvalid), .in_ready(req_tready), .mode(mode),
      .a_rows(a_rows_ff), .a_cols(a_cols_ff), .b_rows(b_rows_ff), .b_cols(b_cols_ff),
      .dim_limit(5'(LIMIT)), .busy(q_ne || back_busy),
      .wr_a(wr_a), .wr_b(wr_b), .q_push(q_push), .q_data(q_in), .q_full(q_full)
   );

   mas_queue #(.WIDTH(CMD_W)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .full(q_full), .not_empty(q_ne), .head(q_head), .pop(q_pop)
   );

   mas_ram #(.WIDTH(DATA_W), .DEPTH(SIDE * SIDE)) u_store_a (
      .clock(clock), .wr_en(wr_a), .wr_addr(wr_addr), .wr_data(wr_value),
      .rd_addr(rd_a_addr), .rd_data(rd_a_data)
   );

   mas_ram #(.WIDTH(DATA_W), .DEPTH(SIDE * SIDE)) u_store_b (
      .clock(clock), .wr_en(wr_b), .wr_addr(wr_addr), .wr_data(wr_value),
      .rd_addr(rd_b_addr), .rd_data(rd_b_data)
   );

   // Back end: walks the result elements and drives the result register.
   mas_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(q_ne), .cmd(q_head), .cmd_pop(q_pop), .busy(back_busy),
      .rd_a_addr(rd_a_addr), .rd_b_addr(rd_b_addr),
      .rd_a_data(rd_a_data), .rd_b_data(rd_b_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_value(res_value), .out_row(res_row), .out_col(res_col),
      .out_last(rsp_tlast), .out_err(rsp_tuser)
   );

   assign rsp_tdata = {2'b00, res_col, res_row, res_value};
endmodule

// File: hdl/mas_checker.sv
`timescale 1ns / 1ps
module mas_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   // An error word carries zero payload and always closes its run.
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == 40'd0)
      else $error("error word malformed");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled word changed");

   // Reset leaves no result word pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind matrix_add_sub_multiply mas_checker u_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
);

// File: sim/tb_matrix_add_sub_multiply.sv
`timescale 1ns / 1ps
module tb_matrix_add_sub_multiply;
   import mas_pkg::*;

   // Shape of one expected result word.
   typedef struct {
      logic [31:0] value;
      logic [2:0]  row;
      logic [2:0]  col;
      logic        last;
      logic        err;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [3:0]  csr_data = '0;

   matrix_add_sub_multiply DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: our own copy of both stores and the four shape registers.
   logic [31:0] store_a [64];
   logic [31:0] store_b [64];
   logic [3:0]  shape [4];

   result_type pending_results[$];
   int      errors = 0;
   int      words_sent = 0;
   int      results_seen = 0;
   int      mult_runs = 0;
   longint  cycles = 0;

   // Saturate an exact value to the 32-bit signed range.
   function automatic logic [31:0] clamp32(input logic signed [69:0] v);
      if (v > 70'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -70'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // Work out every result word that one compute word produces.
   function automatic void predict_compute(input logic [2:0] mode);
      bit ok;
      int rows, cols, len;
      logic signed [69:0] acc;
      result_type res;
      ok = 1;
      for (int i = 0; i < 4; i++)
         if (shape[i] < 1 || shape[i] > 8) ok = 0;
      if (mode == MODE_MUL) begin
         ok = ok && shape[REG_A_COLS] == shape[REG_B_ROWS];
         rows = int'(shape[REG_A_ROWS]); cols = int'(shape[REG_B_COLS]);
      end else begin
         ok = ok && shape[REG_A_ROWS] == shape[REG_B_ROWS]
                 && shape[REG_A_COLS] == shape[REG_B_COLS];
         rows = int'(shape[REG_A_ROWS]); cols = int'(shape[REG_A_COLS]);
      end
      if (!ok) begin
         res = '{32'd0, 3'd0, 3'd0, 1'b1, 1'b1};
         pending_results.push_back(res);
         return;
      end
      len = int'(shape[REG_A_COLS]);
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < cols; c++) begin
            // Eight products of up to 2**62 each need more than 64 bits.
            if (mode == MODE_MUL) begin
               acc = 0;
               for (int k = 0; k < len; k++)
                  acc += 70'($signed(store_a[r*8+k])) * 70'($signed(store_b[k*8+c]));
            end else if (mode == MODE_ADD)
               acc = 70'($signed(store_a[r*8+c])) + 70'($signed(store_b[r*8+c]));
            else
               acc = 70'($signed(store_a[r*8+c])) - 70'($signed(store_b[r*8+c]));
            res.value = clamp32(acc);
            res.row = r[2:0];
            res.col = c[2:0];
            res.last = (r == rows - 1) && (c == cols - 1);
            res.err = 1'b0;
            pending_results.push_back(res);
         end
   endfunction

   // Send one input word, waiting a random gap first. Valid stays high after
   // the handshake so that words can follow back to back; the caller drops it.
   task automatic send_word(input logic [2:0] mode, input logic [2:0] row,
                            input logic [2:0] col, input logic [31:0] value);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, value, col, row, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      if (mode == MODE_LOAD_A) begin
         store_a[{row, col}] = value;
      end else if (mode == MODE_LOAD_B) begin
         store_b[{row, col}] = value;
      end else if (mode <= MODE_MUL) begin
         if (mode == MODE_MUL) mult_runs++;
         predict_compute(mode);
      end
   endtask

   // Wait until every expected word has come, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Register writes happen only while the block is idle.
   task automatic write_shape(input logic [1:0] idx, input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shape[idx] = value;
   endtask

   task automatic set_shapes(input int ar, input int ac, input int br, input int bc);
      drain();
      write_shape(REG_A_ROWS, ar[3:0]);
      write_shape(REG_A_COLS, ac[3:0]);
      write_shape(REG_B_ROWS, br[3:0]);
      write_shape(REG_B_COLS, bc[3:0]);
      csr_valid <= 1'b0;
   endtask

   // Fill every store entry so that no compute word ever reads an unwritten one.
   task automatic fill_stores(input bit extremes);
      logic [31:0] v;
      for (int m = 0; m < 2; m++)
         for (int i = 0; i < 64; i++) begin
            if (extremes)
               v = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else
               v = $urandom();
            send_word(m ? MODE_LOAD_B : MODE_LOAD_A, i[5:3], i[2:0], v);
         end
   endtask

   // Directed: extreme values, every operation, shape errors and unused modes.
   task automatic test_directed();
      fill_stores(1);
      set_shapes(8, 8, 8, 8);
      send_word(MODE_ADD, 3'd0, 3'd0, 32'd0);
      send_word(MODE_SUB, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_word(MODE_MUL, 3'd0, 3'd0, 32'd0);
      send_word(3'd5, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_word(3'd6, 3'd0, 3'd0, 32'd0);
      send_word(3'd7, 3'd5, 3'd2, 32'h1234_5678);
      send_word(MODE_LOAD_A, 3'd0, 3'd0, 32'd0);
      send_word(MODE_LOAD_B, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_word(MODE_MUL, 3'd0, 3'd0, 32'd0);
      set_shapes(1, 1, 1, 1);
      send_word(MODE_ADD, 3'd0, 3'd0, 32'd0);
      send_word(MODE_MUL, 3'd0, 3'd0, 32'd0);
      set_shapes(2, 3, 3, 2);
      send_word(MODE_ADD, 3'd0, 3'd0, 32'd0);
      send_word(MODE_MUL, 3'd0, 3'd0, 32'd0);
      set_shapes(0, 1, 1, 1);
      send_word(MODE_ADD, 3'd0, 3'd0, 32'd0);
      send_word(MODE_MUL, 3'd0, 3'd0, 32'd0);
      set_shapes(9, 15, 9, 15);
      send_word(MODE_SUB, 3'd0, 3'd0, 32'd0);
   endtask

   // Random: reload part of the stores at random; compute on small shapes, then 8x8.
   task automatic test_random();
      int ar, ac, br, bc, pick;
      for (int phase = 0; phase < 12; phase++) begin
         ar = $urandom_range(1, 4); ac = $urandom_range(1, 4);
         pick = $urandom_range(0, 9);
         if (pick < 4) begin br = ar; bc = ac; end
         else if (pick < 8) begin br = ac; bc = $urandom_range(1, 4); end
         else begin br = $urandom_range(0, 15); bc = $urandom_range(0, 15); end
         if (phase == 11) begin ar = 8; ac = 8; br = 8; bc = 8; end
         set_shapes(ar, ac, br, bc);
         for (int n = 0; n < 12; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
               send_word(pick % 2 ? MODE_LOAD_B : MODE_LOAD_A, 3'($urandom()),
                         3'($urandom()),
                         ($urandom_range(0, 3) == 0) ?
                         ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000) : $urandom());
            else if (pick < 9)
               send_word(3'(MODE_ADD + $urandom_range(0, 2)), 3'($urandom()),
                         3'($urandom()), $urandom());
            else
               send_word(3'($urandom_range(5, 7)), 3'($urandom()), 3'($urandom()),
                         $urandom());
         end
      end
   endtask

   // Hold off until the block has emptied out, then keep going.
   task automatic test_pause();
      set_shapes(3, 3, 3, 3);
      send_word(MODE_MUL, 3'd0, 3'd0, 32'd0);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      send_word(MODE_ADD, 3'd0, 3'd0, 32'd0);
   endtask

   // Result checker: the receiver stalls at random before taking each word.
   initial begin
      int stall;
      result_type want;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word %h last %b err %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.value || rsp_tdata[34:32] !== want.row ||
                rsp_tdata[37:35] !== want.col || rsp_tdata[39:38] !== 2'b00 ||
                rsp_tlast !== want.last || rsp_tuser !== want.err) begin
               $display("%0t: expected value %h row %0d col %0d last %b err %b",
                        $time, want.value, want.row, want.col, want.last, want.err);
               $display("%0t: actual   value %h row %0d col %0d last %b err %b",
                        $time, rsp_tdata[31:0], rsp_tdata[34:32], rsp_tdata[37:35],
                        rsp_tlast, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Watchdog well above the slowest correct run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 4; i++) shape[i] = 4'd1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      fill_stores(0);
      test_random();
      test_pause();
      drain();
      $display("Sent %0d words and checked %0d results, including %0d multiply words.",
               words_sent, results_seen, mult_runs);
      $display("Shapes ranged from 1x1 to 8x8, with bad and out-of-range shapes included.");
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

// File: matrix_add_sub_multiply.f
hdl/mas_pkg.sv
hdl/mas_ram.sv
hdl/mas_front.sv
hdl/mas_queue.sv
hdl/mas_back.sv
hdl/matrix_add_sub_multiply.sv
hdl/mas_checker.sv
sim/tb_matrix_add_sub_multiply.sv
